// ----- sv/stt_pkg.sv -----
// Shared types, constants and character codes for the source text tokenizer.
package stt_pkg;

    localparam int LINE_BITS  = 32;
    localparam int LINE_OUT_W = 32;
    localparam int WIDE_W     = 64;

    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_DELIM = 2'd1;
    localparam logic [1:0] KIND_STR   = 2'd2;
    localparam logic [1:0] KIND_CMT   = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_WORD = 4'b0010,
        MODE_STR  = 4'b0100,
        MODE_CMT  = 4'b1000
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t             mode;
        logic                   prev_bslash;
        logic [LINE_BITS-1:0]   line_count;
    } scan_state_t;

    typedef struct packed {
        logic [7:0]             echo_byte;
        logic                   in_token;
        logic                   token_start;
        logic [1:0]             token_kind;
        logic [LINE_OUT_W-1:0]  line_number;
    } scan_result_t;

endpackage

// ----- sv/stt_classifier.sv -----
// Combinational byte classifier: next scan state and labelled result for one byte.
module stt_classifier (
    input  logic [7:0]           char_byte,
    input  logic                 restart,
    input  stt_pkg::scan_state_t state_in,
    output stt_pkg::scan_state_t state_out,
    output stt_pkg::scan_result_t result
);

    stt_pkg::scan_state_t         cur;
    logic                         is_blank;
    logic                         is_single;
    logic                         is_hash;
    logic                         is_quote;
    logic                         is_newline;
    logic                         idle_path;
    logic                         tok;
    logic                         start;
    logic [1:0]                   kind;
    logic [stt_pkg::WIDE_W-1:0]   line_wide;

    always_comb begin
        cur.mode        = stt_pkg::MODE_IDLE;
        cur.prev_bslash = 1'b0;
        cur.line_count  = stt_pkg::LINE_BITS'(1);
        if (!restart) begin
            cur = state_in;
        end
    end

    assign is_newline = (char_byte == stt_pkg::CH_NEWLINE);
    assign is_blank   = (char_byte == stt_pkg::CH_SPACE) ||
                        ((char_byte >= stt_pkg::CH_TAB) && (char_byte <= stt_pkg::CH_CR));
    assign is_hash    = (char_byte == stt_pkg::CH_HASH);
    assign is_quote   = (char_byte == stt_pkg::CH_QUOTE);
    assign is_single  = (char_byte == stt_pkg::CH_COMMA)  || (char_byte == stt_pkg::CH_DOT)    ||
                        (char_byte == stt_pkg::CH_LBRACE) || (char_byte == stt_pkg::CH_RBRACE) ||
                        (char_byte == stt_pkg::CH_EQUALS) || (char_byte == stt_pkg::CH_LPAREN) ||
                        (char_byte == stt_pkg::CH_RPAREN);

    always_comb begin
        state_out = cur;
        idle_path = 1'b0;
        tok       = 1'b1;
        start     = 1'b0;
        kind      = stt_pkg::KIND_WORD;

        case (cur.mode)
            stt_pkg::MODE_WORD: begin
                if (is_blank || is_single || is_hash) begin
                    idle_path = 1'b1;
                end
            end
            stt_pkg::MODE_STR: begin
                kind = stt_pkg::KIND_STR;
                if (is_quote && !cur.prev_bslash) begin
                    state_out.mode        = stt_pkg::MODE_IDLE;
                    state_out.prev_bslash = 1'b0;
                end else begin
                    state_out.prev_bslash = (char_byte == stt_pkg::CH_BACKSLASH);
                end
            end
            stt_pkg::MODE_CMT: begin
                kind = stt_pkg::KIND_CMT;
                if (is_newline) begin
                    idle_path = 1'b1;
                end
            end
            default: begin
                idle_path = 1'b1;
            end
        endcase

        // A byte that ends a word or a comment is handled as if no token were open.
        if (idle_path) begin
            if (is_blank) begin
                tok            = 1'b0;
                kind           = stt_pkg::KIND_WORD;
                state_out.mode = stt_pkg::MODE_IDLE;
                if (is_newline && (cur.line_count != {stt_pkg::LINE_BITS{1'b1}})) begin
                    state_out.line_count = cur.line_count + stt_pkg::LINE_BITS'(1);
                end
            end else begin
                start = 1'b1;
                if (is_hash) begin
                    kind           = stt_pkg::KIND_CMT;
                    state_out.mode = stt_pkg::MODE_CMT;
                end else if (is_quote) begin
                    kind                  = stt_pkg::KIND_STR;
                    state_out.mode        = stt_pkg::MODE_STR;
                    state_out.prev_bslash = 1'b0;
                end else if (is_single) begin
                    kind           = stt_pkg::KIND_DELIM;
                    state_out.mode = stt_pkg::MODE_IDLE;
                end else begin
                    kind           = stt_pkg::KIND_WORD;
                    state_out.mode = stt_pkg::MODE_WORD;
                end
            end
        end
    end

    assign line_wide = stt_pkg::WIDE_W'(state_out.line_count);

    always_comb begin
        result.echo_byte   = char_byte;
        result.in_token    = tok;
        result.token_start = start;
        result.token_kind  = kind;
        if (line_wide[stt_pkg::WIDE_W-1:stt_pkg::LINE_OUT_W] != '0) begin
            result.line_number = {stt_pkg::LINE_OUT_W{1'b1}};
        end else begin
            result.line_number = line_wide[stt_pkg::LINE_OUT_W-1:0];
        end
    end

endmodule

// ----- sv/source_text_tokenizer_unit.sv -----
// Top level of the byte-serial source text tokenizer with a registered result stage.
//
//  Channel  Direction  Carries
//  s_*      in         one source byte and its restart flag per transaction
//  m_*      out        the labelled byte and the current line number per transaction
//
// Each byte is classified in the cycle it is accepted and its result appears on m_*
// in the next cycle; while m_tready is high, one byte per cycle is sustained, set by
// the single result register. Reset (aresetn low, synchronous) empties the result
// register, leaves the scan between tokens and sets the line counter to one.
// A stalled result holds in its register; a new byte is taken in the same cycle as
// the waiting result is taken.
module source_text_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] echo_byte, [39:8] line_number
    output logic [3:0]  m_tuser    // [0] in_token, [1] token_start, [3:2] token_kind
);

    stt_pkg::scan_state_t  state_reg;
    stt_pkg::scan_state_t  state_next;
    stt_pkg::scan_result_t result_reg;
    stt_pkg::scan_result_t result_next;
    logic                  valid_reg;
    logic                  accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    stt_classifier u_classifier (
        .char_byte (s_tdata),
        .restart   (s_tuser),
        .state_in  (state_reg),
        .state_out (state_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg             <= 1'b0;
            state_reg.mode        <= stt_pkg::MODE_IDLE;
            state_reg.prev_bslash <= 1'b0;
            state_reg.line_count  <= stt_pkg::LINE_BITS'(1);
        end else begin
            if (accept) begin
                valid_reg <= 1'b1;
                state_reg <= state_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {result_reg.line_number, result_reg.echo_byte};
    assign m_tuser  = {result_reg.token_kind, result_reg.token_start, result_reg.in_token};

endmodule
